// File: rtl/rmvs_pkg.sv
// Package for the running mean, variance and standard deviation unit.
// Holds the default sizes, fixed field widths and the sequencer state type.
// Used by rmvs_isqrt and running_mean_variance_stddev_unit.
`timescale 1ns / 1ps

package rmvs_pkg;

	localparam int SAMPLE_BITS_DEF = 24;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int COUNT_BITS_DEF  = 16;

	localparam int SUM_BITS  = 64;
	localparam int VAR_BITS  = 48;
	localparam int ROOT_BITS = SUM_BITS / 2;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MDIV = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_VDIV = 6'b001000,
		ST_SQRT = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

endpackage

// File: rtl/rmvs_isqrt.sv
// Digit-serial integer square root, two radicand bits per cycle.
// Depends on rmvs_pkg for the radicand width.
`timescale 1ns / 1ps

module rmvs_isqrt (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [rmvs_pkg::SUM_BITS-1:0]      radicand,
	output logic                               done,
	output logic [rmvs_pkg::ROOT_BITS-1:0]     root
);

	localparam int RB = rmvs_pkg::ROOT_BITS;
	localparam int SB = rmvs_pkg::SUM_BITS;
	localparam int CW = $clog2(RB);

	logic          busy_q;
	logic [CW-1:0] step_q;
	logic [SB-1:0] x_q;
	logic [RB-1:0] rem_q;
	logic [RB-1:0] root_q;
	logic          done_q;
	logic [RB+1:0] trial;
	logic [RB+1:0] part;
	logic          ge;

	assign part  = {rem_q, x_q[SB-1:SB-2]};
	assign trial = {root_q, 2'b01};
	assign ge    = part >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == CW'(RB - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[SB-3:0], 2'b00};
			rem_q  <= ge ? RB'(part - trial) : RB'(part);
			root_q <= {root_q[RB-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: rtl/running_mean_variance_stddev_unit.sv
// Running mean, sample variance and standard deviation by Welford's method.
// Depends on rmvs_pkg and rmvs_isqrt.
`timescale 1ns / 1ps

// One sample is taken at a time and yields one result. The mean update divides
// the deviation by the count one bit per cycle, the product of deviations is
// formed by shift and add, the sum is divided by count minus one one bit per
// cycle and the root of that quotient is then taken. A new sample is taken only
// once the previous one is through all steps and its result is loaded into the
// output register, and the unit waits for that register to be free. A sample
// ignored at full count skips the mean and product steps. The first sample of a
// set skips the arithmetic entirely. The next sample is taken while the previous
// result still waits in the output register.
module running_mean_variance_stddev_unit #(
	parameter int SAMPLE_BITS = rmvs_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = rmvs_pkg::FRAC_BITS_DEF,
	parameter int COUNT_BITS  = rmvs_pkg::COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// sample_value
	input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// start_new_set
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// sample_count, running_mean, sample_variance, std_deviation, count_overflow
	output logic [((COUNT_BITS + SAMPLE_BITS + rmvs_pkg::VAR_BITS + rmvs_pkg::ROOT_BITS + 8) / 8)
		* 8 - 1:0] m_tdata
);

	localparam int SB   = SAMPLE_BITS;
	localparam int CB   = COUNT_BITS;
	localparam int SUMB = rmvs_pkg::SUM_BITS;
	localparam int VB   = rmvs_pkg::VAR_BITS;
	localparam int RB   = rmvs_pkg::ROOT_BITS;
	localparam int PW   = 2 * (SB + 1);
	localparam int SX   = (PW > SUMB) ? PW + 1 : SUMB + 1;
	localparam int OW   = CB + SB + VB + RB + 1;
	localparam int OWP  = ((OW + 7) / 8) * 8;
	localparam int STW  = $clog2(SUMB + 1);
	localparam logic [CB-1:0] CNT_MAX = '1;

	rmvs_pkg::state_t state_q;

	logic [CB-1:0]   count_q;
	logic [SB-1:0]   mean_q;
	logic [SUMB-1:0] sum_q;
	logic [SB-1:0]   samp_q;
	logic            ovf_q;
	logic            neg_q;
	logic [SB:0]     absd_q;
	logic [SUMB-1:0] dsr_q;
	logic [CB-1:0]   div_q;
	logic [CB-1:0]   rem_q;
	logic [STW-1:0]  step_q;
	logic [PW-1:0]   acc_q;
	logic [PW-1:0]   mcand_q;
	logic [SB:0]     mplier_q;
	logic [VB-1:0]   var_q;
	logic [RB-1:0]   std_q;
	logic [OWP-1:0]  out_q;
	logic            out_valid_q;

	logic            accept;
	logic            start_flag;
	logic            ovf_now;
	logic [CB-1:0]   cnt_new;
	logic [SB+1:0]   delta;
	logic [CB:0]     tdiv;
	logic            dge;
	logic [SUMB-1:0] dsr_nx;
	logic [CB-1:0]   rem_nx;
	logic [SB+1:0]   qsig;
	logic [SB+1:0]   mean_nx;
	logic [SB+1:0]   err;
	logic [PW-1:0]   acc_nx;
	logic [SX-1:0]   sum_x;
	logic [SUMB-1:0] sum_nx;
	logic [SUMB-1:0] var_x;
	logic            sq_start;
	logic            sq_done;
	logic [RB-1:0]   sq_root;
	logic            out_free;

	assign accept     = s_tvalid && s_tready;
	assign s_tready   = (state_q == rmvs_pkg::ST_IDLE);
	assign start_flag = s_tuser;
	assign ovf_now    = !start_flag && (count_q == CNT_MAX);
	assign cnt_new    = start_flag ? CB'(1) : (ovf_now ? count_q : count_q + 1'b1);
	assign delta      = (SB + 2)'($signed(s_tdata[SB-1:0])) - (SB + 2)'($signed(mean_q));

	assign tdiv   = {rem_q, dsr_q[SUMB-1]};
	assign dge    = tdiv >= {1'b0, div_q};
	assign rem_nx = dge ? CB'(tdiv - {1'b0, div_q}) : tdiv[CB-1:0];
	assign dsr_nx = {dsr_q[SUMB-2:0], dge};

	assign qsig    = neg_q ? (SB + 2)'(-{1'b0, dsr_nx[SB:0]}) : {1'b0, dsr_nx[SB:0]};
	assign mean_nx = (SB + 2)'($signed(mean_q)) + qsig;
	assign err     = (SB + 2)'($signed(samp_q)) - mean_nx;

	assign acc_nx = acc_q + (mplier_q[0] ? mcand_q : '0);
	assign sum_x  = SX'(sum_q) + SX'(acc_nx);
	assign sum_nx = (|sum_x[SX-1:SUMB]) ? '1 : sum_x[SUMB-1:0];
	assign var_x  = dsr_nx >> FRAC_BITS;

	assign sq_start = (state_q == rmvs_pkg::ST_VDIV) && (step_q == STW'(SUMB - 1));
	assign out_free = !out_valid_q || m_tready;

	rmvs_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (dsr_nx),
		.done     (sq_done),
		.root     (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rmvs_pkg::ST_IDLE;
			count_q     <= '0;
			mean_q      <= '0;
			sum_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == rmvs_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				rmvs_pkg::ST_IDLE: begin
					if (accept) begin
						count_q <= cnt_new;
						step_q  <= '0;
						if (!ovf_now && cnt_new == CB'(1)) begin
							mean_q  <= s_tdata[SB-1:0];
							sum_q   <= '0;
							state_q <= rmvs_pkg::ST_DONE;
						end else if (ovf_now) begin
							state_q <= rmvs_pkg::ST_VDIV;
						end else begin
							state_q <= rmvs_pkg::ST_MDIV;
						end
					end
				end
				rmvs_pkg::ST_MDIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STW'(SB)) begin
						mean_q  <= mean_nx[SB-1:0];
						step_q  <= '0;
						state_q <= rmvs_pkg::ST_MUL;
					end
				end
				rmvs_pkg::ST_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == STW'(SB)) begin
						sum_q   <= sum_nx;
						step_q  <= '0;
						state_q <= rmvs_pkg::ST_VDIV;
					end
				end
				rmvs_pkg::ST_VDIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STW'(SUMB - 1)) begin
						state_q <= rmvs_pkg::ST_SQRT;
					end
				end
				rmvs_pkg::ST_SQRT: begin
					if (sq_done) begin
						state_q <= rmvs_pkg::ST_DONE;
					end
				end
				rmvs_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= rmvs_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= rmvs_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rmvs_pkg::ST_IDLE: begin
				samp_q <= s_tdata[SB-1:0];
				ovf_q  <= ovf_now;
				neg_q  <= delta[SB+1];
				absd_q <= delta[SB+1] ? (SB + 1)'(-delta) : delta[SB:0];
				rem_q  <= '0;
				var_q  <= '0;
				std_q  <= '0;
				if (ovf_now) begin
					dsr_q <= sum_q;
					div_q <= count_q - 1'b1;
				end else begin
					dsr_q <= SUMB'(delta[SB+1] ? (SB + 1)'(-delta) : delta[SB:0]) << (SUMB - SB - 1);
					div_q <= cnt_new;
				end
			end
			rmvs_pkg::ST_MDIV: begin
				dsr_q    <= dsr_nx;
				rem_q    <= rem_nx;
				acc_q    <= '0;
				mcand_q  <= PW'(absd_q);
				mplier_q <= err[SB+1] ? (SB + 1)'(-err) : err[SB:0];
			end
			rmvs_pkg::ST_MUL: begin
				acc_q    <= acc_nx;
				mcand_q  <= {mcand_q[PW-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[SB:1]};
				dsr_q    <= sum_nx;
				rem_q    <= '0;
				div_q    <= count_q - 1'b1;
			end
			rmvs_pkg::ST_VDIV: begin
				dsr_q <= dsr_nx;
				rem_q <= rem_nx;
				var_q <= (|var_x[SUMB-1:VB]) ? '1 : var_x[VB-1:0];
			end
			rmvs_pkg::ST_SQRT: begin
				std_q <= sq_root;
			end
			default: begin
				if (out_free) begin
					out_q <= OWP'({ovf_q, std_q, var_q, mean_q, count_q});
				end
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[CB-1:0] != '0)
		else $error("result with zero count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[OW-1]) |-> m_tdata[CB-1:0] == CNT_MAX)
		else $error("overflow flag without full count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[CB-1:0] == CB'(1)) |-> m_tdata[OW-2:CB+SB] == '0)
		else $error("nonzero spread for a single sample");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("result dropped while stalled");

endmodule

// File: bench/running_mean_variance_stddev_unit_tb.sv
// Self-checking testbench for the running mean, variance and standard deviation unit.
// Predicts each result from its own Welford recurrence and compares every output transfer.
// Depends on rmvs_pkg and the unit under test only.
`timescale 1ns / 1ps

module running_mean_variance_stddev_unit_tb;

	localparam int SB = rmvs_pkg::SAMPLE_BITS_DEF;
	localparam int CB = rmvs_pkg::COUNT_BITS_DEF;
	localparam int FB = rmvs_pkg::FRAC_BITS_DEF;
	localparam int SDW = ((SB + 7) / 8) * 8;
	localparam int MDW = ((CB + SB + rmvs_pkg::VAR_BITS + rmvs_pkg::ROOT_BITS + 8) / 8) * 8;
	localparam longint unsigned COUNT_TOP = (64'd1 << CB) - 1;
	localparam longint unsigned VAR_TOP = (64'd1 << rmvs_pkg::VAR_BITS) - 1;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic ovf;
		logic [31:0] sd;
		logic [47:0] vr;
		logic [SB-1:0] mean;
		logic [CB-1:0] cnt;
	} stats_t;

	typedef struct {
		logic signed [SB-1:0] sample;
		logic start;
		logic typed;
		stats_t want;
	} vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// sample_value
	logic [SDW-1:0] s_tdata = '0;
	// start_new_set
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// sample_count, running_mean, sample_variance, std_deviation, count_overflow
	logic [MDW-1:0] m_tdata;

	stats_t stats_q[$];
	idle_mode_t mode = IDLE_NONE;
	logic hold_off = 1'b0;
	event stall_ev;
	int errors = 0;
	int results_seen = 0;
	int starts_sent = 0;

	longint unsigned set_count = 0;
	longint signed set_mean = 0;
	longint unsigned dev_sum = 0;

	running_mean_variance_stddev_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic stats_t welford_update(logic signed [SB-1:0] sample, logic start);
		stats_t r;
		longint signed d;
		longint signed delta;
		longint signed nm;
		longint unsigned prod;
		longint unsigned q;
		longint unsigned v;
		d = sample;
		r = '0;
		if (start) set_count = 0;
		if (set_count >= COUNT_TOP) begin
			r.ovf = 1'b1;
		end else begin
			set_count++;
			if (set_count == 1) begin
				set_mean = d;
				dev_sum = 0;
			end else begin
				delta = d - set_mean;
				nm = set_mean + delta / longint'(set_count);
				prod = longint'(delta) * longint'(d - nm);
				if (dev_sum > 64'hFFFF_FFFF_FFFF_FFFF - prod) dev_sum = 64'hFFFF_FFFF_FFFF_FFFF;
				else dev_sum = dev_sum + prod;
				set_mean = nm;
			end
		end
		if (set_count >= 2) begin
			q = dev_sum / (set_count - 1);
			v = q >> FB;
			r.vr = 48'((v > VAR_TOP) ? VAR_TOP : v);
			r.sd = 32'(int_sqrt(q));
		end
		r.cnt = CB'(set_count);
		r.mean = SB'(set_mean);
		return r;
	endfunction

	task automatic send_sample(logic signed [SB-1:0] sample, logic start, logic typed,
			stats_t want);
		stats_t p;
		while ((mode == IDLE_SEND && $urandom_range(99) < 49) ||
				(mode == IDLE_BOTH && $urandom_range(99) < 34)) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= SDW'(sample);
		s_tuser <= start;
		do @(posedge clk); while (!s_tready);
		p = welford_update(sample, start);
		stats_q = {stats_q, (typed ? want : p)};
		if (start) starts_sent++;
	endtask

	always begin
		@(stall_ev);
		hold_off <= 1'b1;
		repeat (2000) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		stats_t got;
		stats_t exp_r;
		if (m_tvalid && m_tready) begin
			got = m_tdata[$bits(stats_t)-1:0];
			results_seen++;
			if (stats_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected transfer %h", got);
			end else begin
				exp_r = stats_q.pop_front();
				if (got !== exp_r) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: cnt %0d/%0d mean %h/%h var %h/%h sd %h/%h ovf %b/%b",
							exp_r.cnt, got.cnt, exp_r.mean, got.mean, exp_r.vr, got.vr,
							exp_r.sd, got.sd, exp_r.ovf, got.ovf);
				end
			end
		end
		if (hold_off) begin
			m_tready <= 1'b0;
		end else if (mode == IDLE_RECV) begin
			m_tready <= ($urandom_range(99) >= 49);
		end else if (mode == IDLE_BOTH) begin
			m_tready <= ($urandom_range(99) >= 34);
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		#50ms;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		vec_t dir[$];
		logic signed [SB-1:0] smp;
		int k;
		dir = '{
			'{24'sh7FFFFF, 1'b0, 1'b1, '{1'b0, 32'd0, 48'd0, 24'h7FFFFF, 16'd1}},
			'{24'sh800000, 1'b0, 1'b0, '0},
			'{24'sh000000, 1'b0, 1'b0, '0},
			'{24'sh800000, 1'b1, 1'b1, '{1'b0, 32'd0, 48'd0, 24'h800000, 16'd1}},
			'{24'sh7FFFFF, 1'b0, 1'b0, '0},
			'{24'sh010000, 1'b1, 1'b1, '{1'b0, 32'd0, 48'd0, 24'h010000, 16'd1}},
			'{24'sh020000, 1'b0, 1'b0, '0},
			'{24'sh000001, 1'b0, 1'b0, '0},
			'{24'shFFFFFF, 1'b0, 1'b0, '0},
			'{24'sh000000, 1'b1, 1'b1, '{1'b0, 32'd0, 48'd0, 24'h000000, 16'd1}},
			'{24'sh000000, 1'b0, 1'b1, '{1'b0, 32'd0, 48'd0, 24'h000000, 16'd2}},
			'{24'sh7FFFFF, 1'b1, 1'b1, '{1'b0, 32'd0, 48'd0, 24'h7FFFFF, 16'd1}},
			'{24'sh800000, 1'b0, 1'b0, '0},
			'{24'sh555555, 1'b0, 1'b0, '0},
			'{24'shAAAAAA, 1'b0, 1'b0, '0}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir[i]) send_sample(dir[i].sample, dir[i].start, dir[i].typed, dir[i].want);
		for (int ph = 0; ph < 4; ph++) begin
			mode = idle_mode_t'(ph);
			for (int n = 0; n < 400; n++) begin
				if (ph == 0 && n == 100) -> stall_ev;
				k = $urandom_range(9);
				if (k < 5) smp = SB'($urandom);
				else if (k < 8) smp = SB'($signed(SB'($urandom_range(4095))) - 2048);
				else smp = (k == 8) ? 24'sh7FFFFF : 24'sh800000;
				send_sample(smp, ($urandom_range(39) == 0), 1'b0, '0);
			end
			s_tvalid <= 1'b0;
			wait (stats_q.size() == 0);
			repeat (200) @(posedge clk);
		end
		$display("covered %0d results over four idling phases, %0d fresh sets, one long stall",
			results_seen, starts_sent);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches counted", errors);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
